/* design/round_robin_process_scheduler_unit_macros.svh */
// Assertion macros for the round-robin process scheduler.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rrps_pkg.sv */
// Package: command/result payload types and code constants of the scheduler.
package rrps_pkg;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_EXIT    = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_SUSPEND = 3'd3;
  localparam logic [2:0] REQ_RESUME  = 3'd4;
  localparam logic [2:0] REQ_MOVE    = 3'd5;
  localparam logic [2:0] REQ_SCHED   = 3'd6;
  localparam logic [2:0] REQ_RESCHED = 3'd7;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_RUNNING  = 3'd1;
  localparam logic [2:0] ST_RESUMING = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;
  localparam logic [2:0] ST_EXITED   = 3'd5;

  localparam logic CFG_IDLE_SLOT  = 1'b0;
  localparam logic CFG_BLOCK_MASK = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] proc_id;
    logic [7:0] block_flags;
    logic [7:0] exit_status;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] current_id;
    logic       ran_idle;
    logic       need_resched_out;
    logic       restart_syscall;
    logic [2:0] slot_state;
    logic [7:0] slot_exit_code;
  } res_t;

endpackage

/* design/rrps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/round_robin_process_scheduler_unit.sv */
// Top level: round-robin process scheduler, slot table in one RAM, command sequencer.
// Move-after-current commands take longest, request-reschedule commands shortest.
// Throughput: one command at a time; busy falls with done, so the next start can
//   be taken in the done cycle.
// Reset: rst (synchronous) clears slot valid bits, list, current slot and pending flag;
//   slots read as unused until first written. done is never held off.
`include "round_robin_process_scheduler_unit_macros.svh"

module round_robin_process_scheduler_unit #(
  parameter int NUM_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rrps_pkg::cmd_t cmd,
  output logic          done,
  output rrps_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);

  localparam int IW    = $clog2(NUM_SLOTS);
  localparam int DEPTH = 1 << IW;

  typedef struct packed {
    logic          nil;
    logic [IW-1:0] id;
  } lnk_t;

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] fl;
    logic [7:0] cd;
    lnk_t       nxt;
    lnk_t       prv;
  } word_t;

  localparam int    WW         = $bits(word_t);
  localparam lnk_t  LNK_NIL    = '{nil: 1'b1, id: '0};
  localparam word_t RESET_WORD = '{st: rrps_pkg::ST_UNUSED, fl: 8'd0, cd: 8'd0,
                                   nxt: LNK_NIL, prv: LNK_NIL};

  typedef enum logic [4:0] {
    S_IDLE, S_P, S_T_W, S_C, S_X_W, S_PP_R, S_PP_W, S_NN_R, S_NN_W,
    S_LA_R, S_LA_W, S_LN_R, S_LN_W, S_F_P, S_F_PW, S_F_C
  } state_t;

  function automatic logic [IW-1:0] to_idx(input logic [3:0] v);
    logic [8:0] e;
    e = {5'b0, v};
    return e[IW-1:0];
  endfunction

  function automatic logic [3:0] to_id(input logic [IW-1:0] v);
    logic [8:0] e;
    e = '0;
    e[IW-1:0] = v;
    return e[3:0];
  endfunction

  function automatic logic in_range(input logic [3:0] v);
    return 32'(v) < 32'(NUM_SLOTS);
  endfunction

  state_t         state;
  rrps_pkg::cmd_t cmd_r;
  logic [IW-1:0]  pidx;
  logic           pvalid;
  logic [3:0]     idle_slot;
  logic [7:0]     block_cond_mask;
  lnk_t           head, tail, pp, nn, n2;
  logic           cur_nil;
  logic [3:0]     cur_id;
  logic           pend, acc, restart, la;
  logic [IW-1:0]  nx_r;
  word_t          wp;
  logic [2:0]     sst;
  logic [7:0]     scode;
  logic [DEPTH-1:0] vld;
  logic           rd_vld;

  logic           we;
  logic [IW-1:0]  waddr, raddr;
  word_t          wdata, rw;
  logic [WW-1:0]  ram_q;

  logic           p_onl, p_ok, cur_in, use_next, nx_in;
  logic [IW-1:0]  cur_idx;
  logic [3:0]     nx4;
  word_t          np;

  rrps_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rw       = rd_vld ? word_t'(ram_q) : RESET_WORD;
    p_onl    = (rw.st == rrps_pkg::ST_RUNNING) || (rw.st == rrps_pkg::ST_RESUMING);
    cur_in   = !cur_nil && in_range(cur_id);
    cur_idx  = to_idx(cur_id);
    use_next = cur_in && p_onl && !rw.nxt.nil;
    if (use_next) begin
      nx4 = to_id(rw.nxt.id);
    end else if (!head.nil) begin
      nx4 = to_id(head.id);
    end else begin
      nx4 = idle_slot;
    end
    nx_in = in_range(nx4);

    np     = rw;
    np.nxt = LNK_NIL;
    np.prv = LNK_NIL;
    p_ok   = 1'b0;
    unique case (cmd_r.req_type)
      rrps_pkg::REQ_INSERT: begin
        p_ok   = (rw.st == rrps_pkg::ST_UNUSED) || (rw.st == rrps_pkg::ST_EXITED);
        np.st  = rrps_pkg::ST_RUNNING;
        np.fl  = 8'd0;
        np.cd  = 8'd0;
        np.prv = tail;
      end
      rrps_pkg::REQ_EXIT: begin
        p_ok  = (rw.st != rrps_pkg::ST_EXITED);
        np.st = rrps_pkg::ST_EXITED;
        np.cd = cmd_r.exit_status;
      end
      rrps_pkg::REQ_STOP: begin
        p_ok  = (rw.st != rrps_pkg::ST_EXITED) && (rw.st != rrps_pkg::ST_STOPPED);
        np.st = rrps_pkg::ST_STOPPED;
      end
      rrps_pkg::REQ_SUSPEND: begin
        p_ok  = (rw.st == rrps_pkg::ST_RUNNING);
        np.st = rrps_pkg::ST_BLOCKED;
        np.fl = rw.fl | (cmd_r.block_flags & block_cond_mask);
      end
      rrps_pkg::REQ_RESUME: begin
        p_ok   = !p_onl && (rw.st != rrps_pkg::ST_EXITED);
        np.st  = rrps_pkg::ST_RESUMING;
        np.prv = tail;
      end
      rrps_pkg::REQ_MOVE: begin
        p_ok = p_onl && cur_in && (cur_id != cmd_r.proc_id);
      end
      default: begin
        p_ok = 1'b0;
      end
    endcase

    we    = 1'b0;
    waddr = pidx;
    wdata = rw;
    raddr = pidx;
    unique case (state)
      S_IDLE: begin
        raddr = (cmd.req_type == rrps_pkg::REQ_SCHED) ? cur_idx : to_idx(cmd.proc_id);
      end
      S_P: begin
        if (cmd_r.req_type == rrps_pkg::REQ_MOVE) begin
          raddr = cur_idx;
        end else begin
          we    = p_ok;
          wdata = np;
          raddr = tail.id;
        end
      end
      S_T_W: begin
        we          = 1'b1;
        waddr       = tail.id;
        wdata.nxt   = '{nil: 1'b0, id: pidx};
      end
      S_C: begin
        raddr = to_idx(nx4);
      end
      S_X_W: begin
        we    = (rw.st == rrps_pkg::ST_RESUMING);
        waddr = nx_r;
        wdata.st    = rrps_pkg::ST_RUNNING;
        wdata.fl[0] = 1'b0;
      end
      S_PP_R: begin
        raddr = pp.id;
      end
      S_PP_W: begin
        we        = 1'b1;
        waddr     = pp.id;
        wdata.nxt = nn;
      end
      S_NN_R: begin
        raddr = nn.id;
      end
      S_NN_W: begin
        we        = 1'b1;
        waddr     = nn.id;
        wdata.prv = pp;
      end
      S_LA_R: begin
        raddr = cur_idx;
      end
      S_LA_W: begin
        we        = 1'b1;
        waddr     = cur_idx;
        wdata.nxt = '{nil: 1'b0, id: pidx};
      end
      S_LN_R: begin
        we        = 1'b1;
        waddr     = pidx;
        wdata     = wp;
        wdata.prv = '{nil: 1'b0, id: cur_idx};
        wdata.nxt = n2;
        raddr     = n2.id;
      end
      S_LN_W: begin
        we        = 1'b1;
        waddr     = n2.id;
        wdata.prv = '{nil: 1'b0, id: pidx};
      end
      S_F_P: begin
        raddr = pidx;
      end
      S_F_PW: begin
        raddr = cur_idx;
      end
      S_F_C: begin
        raddr = pidx;
      end
      default: begin
        raddr = pidx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      idle_slot       <= 4'd0;
      block_cond_mask <= 8'hFF;
      head            <= LNK_NIL;
      tail            <= LNK_NIL;
      cur_nil         <= 1'b1;
      cur_id          <= 4'd0;
      pend            <= 1'b0;
      vld             <= '0;
      rd_vld          <= 1'b0;
      done            <= 1'b0;
      acc             <= 1'b0;
      restart         <= 1'b0;
      la              <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= vld[raddr];
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rrps_pkg::CFG_IDLE_SLOT) begin
          idle_slot <= cfg_data[3:0];
        end else begin
          block_cond_mask <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            pidx    <= to_idx(cmd.proc_id);
            pvalid  <= in_range(cmd.proc_id);
            acc     <= 1'b0;
            restart <= 1'b0;
            la      <= 1'b0;
            if (cmd.req_type == rrps_pkg::REQ_SCHED) begin
              state <= S_C;
            end else if (cmd.req_type == rrps_pkg::REQ_RESCHED) begin
              pend  <= 1'b1;
              acc   <= 1'b1;
              state <= S_F_P;
            end else if (in_range(cmd.proc_id)) begin
              state <= S_P;
            end else begin
              state <= S_F_P;
            end
          end
        end
        S_P: begin
          wp <= rw;
          pp <= rw.prv;
          nn <= rw.nxt;
          if (!p_ok) begin
            state <= S_F_P;
          end else if (cmd_r.req_type == rrps_pkg::REQ_MOVE) begin
            state <= S_C;
          end else if (cmd_r.req_type == rrps_pkg::REQ_INSERT ||
                       cmd_r.req_type == rrps_pkg::REQ_RESUME) begin
            acc <= 1'b1;
            if (tail.nil) begin
              head  <= '{nil: 1'b0, id: pidx};
              tail  <= '{nil: 1'b0, id: pidx};
              state <= S_F_P;
            end else begin
              state <= S_T_W;
            end
          end else begin
            acc   <= 1'b1;
            pend  <= 1'b1;
            state <= p_onl ? S_PP_R : S_F_P;
          end
        end
        S_T_W: begin
          tail  <= '{nil: 1'b0, id: pidx};
          state <= S_F_P;
        end
        S_C: begin
          if (cmd_r.req_type == rrps_pkg::REQ_MOVE) begin
            if (p_onl) begin
              acc   <= 1'b1;
              la    <= 1'b1;
              state <= S_PP_R;
            end else begin
              state <= S_F_P;
            end
          end else begin
            pend    <= 1'b0;
            acc     <= 1'b1;
            cur_nil <= 1'b0;
            cur_id  <= nx4;
            nx_r    <= to_idx(nx4);
            state   <= nx_in ? S_X_W : S_F_P;
          end
        end
        S_X_W: begin
          if (rw.st == rrps_pkg::ST_RESUMING) begin
            restart <= rw.fl[0];
          end
          state <= S_F_P;
        end
        S_PP_R: begin
          if (pp.nil) begin
            head  <= nn;
            state <= S_NN_R;
          end else begin
            state <= S_PP_W;
          end
        end
        S_PP_W: begin
          state <= S_NN_R;
        end
        S_NN_R: begin
          if (nn.nil) begin
            tail  <= pp;
            state <= la ? S_LA_R : S_F_P;
          end else begin
            state <= S_NN_W;
          end
        end
        S_NN_W: begin
          state <= la ? S_LA_R : S_F_P;
        end
        S_LA_R: begin
          state <= S_LA_W;
        end
        S_LA_W: begin
          n2    <= rw.nxt;
          state <= S_LN_R;
        end
        S_LN_R: begin
          if (n2.nil) begin
            tail  <= '{nil: 1'b0, id: pidx};
            state <= S_F_P;
          end else begin
            state <= S_LN_W;
          end
        end
        S_LN_W: begin
          state <= S_F_P;
        end
        S_F_P: begin
          state <= S_F_PW;
        end
        S_F_PW: begin
          sst   <= pvalid ? rw.st : rrps_pkg::ST_UNUSED;
          scode <= pvalid ? rw.cd : 8'd0;
          state <= S_F_C;
        end
        S_F_C: begin
          result.accepted         <= acc;
          result.current_id       <= cur_nil ? 4'd0 : cur_id;
          result.ran_idle         <= !cur_nil && (cur_id == idle_slot) && !(cur_in && p_onl);
          result.need_resched_out <= pend;
          result.restart_syscall  <= restart;
          result.slot_state       <= sst;
          result.slot_exit_code   <= scode;
          done                    <= 1'b1;
          state                   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RRPS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `RRPS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done, "accepted command not in work")
  `RRPS_ASSERT_NOW(a_list_ends, clk, rst, !busy, head.nil == tail.nil, "run list head and tail disagree")

endmodule
